/* sv/wildcard_pattern_matcher_assert.svh */
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_assert
// Assertion macros used by the checker file of the wildcard pattern matcher.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_PATTERN_MATCHER_ASSERT_SVH
`define WILDCARD_PATTERN_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wildcard pattern matcher assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wildcard pattern matcher assertion failed");

`endif

/* sv/wpm_pkg.sv */
// ----------------------------------------------------------------------------
// wpm_pkg
// Types, constants and the segmented scan used by the wildcard pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

  localparam int MaxPattern = 32;
  localparam int VecW       = MaxPattern + 1;
  localparam int LenW       = $clog2(MaxPattern + 1);
  localparam int IdxW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int SymW       = 8;
  localparam int ModeW      = 2;

  localparam logic [SymW-1:0] StarChar = 8'h2A;
  localparam logic [SymW-1:0] AnyChar  = 8'h3F;

  typedef logic [VecW-1:0] vec_t;

  typedef enum logic [ModeW-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_TEXT   = 2'd2,
    MODE_FINISH = 2'd3
  } mode_e;

  typedef struct packed {
    logic clear;
    logic store;
    logic ovf_set;
    logic consume;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic full;
  } status_t;

  // Result bit i is g[i], or p[i] and result bit i-1, computed as a log-depth prefix.
  function automatic vec_t seg_scan(vec_t g, vec_t p);
    vec_t gg;
    vec_t pp;
    vec_t gn;
    vec_t pn;
    gg = g;
    pp = p;
    for (int d = 1; d < VecW; d = d * 2) begin
      gn = gg;
      pn = pp;
      for (int i = d; i < VecW; i++) begin
        gn[i] = gg[i] | (pp[i] & gg[i-d]);
        pn[i] = pp[i] & pp[i-d];
      end
      gg = gn;
      pp = pn;
    end
    return gg;
  endfunction

endpackage

`default_nettype wire

/* sv/wpm_if.sv */
// ----------------------------------------------------------------------------
// wpm_if
// Valid/ready channel interfaces for the input and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpm_in_if import wpm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ModeW-1:0] mode;
  logic [SymW-1:0]  symbol;

  modport source (output valid, output mode, output symbol, input ready);
  modport sink (input valid, input mode, input symbol, output ready);
endinterface

interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic overflow;

  modport source (output valid, output matched, output overflow, input ready);
  modport sink (input valid, input matched, input overflow, output ready);
endinterface

`default_nettype wire

/* sv/wpm_ctrl.sv */
// ----------------------------------------------------------------------------
// wpm_ctrl
// Controller: handshakes, mode decode and result hold state.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_ctrl import wpm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ModeW-1:0] mode_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire status_t          status_i,
  output cmd_t                  cmd_o
);

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_HOLD = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_RUN) || out_ready_i;
  assign out_valid_o = (state_q == ST_HOLD);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    if (accept) begin
      unique case (mode_e'(mode_i))
        MODE_CLEAR:  cmd_o.clear   = 1'b1;
        MODE_APPEND: begin
          cmd_o.store   = !status_i.full;
          cmd_o.ovf_set = status_i.full;
        end
        MODE_TEXT:   cmd_o.consume = 1'b1;
        MODE_FINISH: cmd_o.finish  = 1'b1;
        default:     cmd_o         = '0;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (cmd_o.finish) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready_i && !cmd_o.finish) state_d = ST_RUN;
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* sv/wpm_dp.sv */
// ----------------------------------------------------------------------------
// wpm_dp
// Datapath: pattern cells, prefix match vector and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_dp import wpm_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cmd_t            cmd_i,
  input  wire logic [SymW-1:0] symbol_i,
  output status_t              status_o,
  output logic                 matched_o,
  output logic                 overflow_o
);

  logic [SymW-1:0] pat_q [MaxPattern];
  logic [LenW-1:0] len_q, len_d;
  vec_t            vec_q, vec_d;
  logic            ovf_q, ovf_d;
  logic            matched_q;
  logic            overflow_q;

  vec_t star;
  vec_t hit;
  vec_t closed;
  vec_t gen;
  vec_t nxt;

  always_comb begin
    star = '0;
    hit  = '0;
    for (int i = 1; i < VecW; i++) begin
      star[i] = (LenW'(i) <= len_q) && (pat_q[i-1] == StarChar);
      hit[i]  = (LenW'(i) <= len_q) &&
                ((pat_q[i-1] == AnyChar) || (pat_q[i-1] == symbol_i));
    end
  end

  assign closed = seg_scan(vec_q, star);

  always_comb begin
    gen = '0;
    for (int i = 1; i < VecW; i++) begin
      gen[i] = star[i] ? closed[i] : (hit[i] & closed[i-1]);
    end
  end

  assign nxt = seg_scan(gen, star);

  assign status_o.full = (len_q == LenW'(MaxPattern));

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    vec_d = vec_q;
    if (cmd_i.clear) begin
      len_d = '0;
      ovf_d = 1'b0;
      vec_d = VecW'(1);
    end else if (cmd_i.store) begin
      len_d = len_q + LenW'(1);
      vec_d = VecW'(1);
    end else if (cmd_i.ovf_set) begin
      ovf_d = 1'b1;
      vec_d = VecW'(1);
    end else if (cmd_i.consume) begin
      vec_d = nxt;
    end else if (cmd_i.finish) begin
      vec_d = VecW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
      vec_q <= VecW'(1);
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
      vec_q <= vec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      pat_q[len_q[IdxW-1:0]] <= symbol_i;
    end
    if (cmd_i.finish) begin
      matched_q  <= closed[len_q];
      overflow_q <= ovf_q;
    end
  end

  assign matched_o  = matched_q;
  assign overflow_o = overflow_q;

endmodule

`default_nettype wire

/* sv/wildcard_pattern_matcher.sv */
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Matches streamed text against a stored pattern with star and question marks.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload            Beat produced
//   in_i     sink       mode, symbol       every command or text byte
//   out_o    source     matched, overflow  one per end-of-text beat
//
// Each input beat is taken while in_i is ready; all pattern cells update in parallel.
// The result of an end-of-text beat is registered and shown the next cycle.
// While a result waits and out_o is not ready, in_i is stalled.
// Reset empties the pattern, clears the overflow flag and re-arms the match vector.
// Pattern cell contents are undefined after reset until written.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_pattern_matcher import wpm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wpm_in_if.sink     in_i,
  wpm_out_if.source  out_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    out_valid;
  logic    matched;
  logic    overflow;

  wpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .mode_i      (in_i.mode),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wpm_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .symbol_i   (in_i.symbol),
    .status_o   (status),
    .matched_o  (matched),
    .overflow_o (overflow)
  );

  assign in_i.ready     = in_ready;
  assign out_o.valid    = out_valid;
  assign out_o.matched  = matched;
  assign out_o.overflow = overflow;

endmodule

`default_nettype wire

/* sv/wpm_checker.sv */
// ----------------------------------------------------------------------------
// wpm_checker
// Port-level checks for the wildcard pattern matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wildcard_pattern_matcher_assert.svh"

module wpm_checker import wpm_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic [ModeW-1:0] in_mode_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic             out_matched_i,
  input wire logic             out_overflow_i
);

  logic acc_clear;
  logic acc_finish;

  assign acc_clear  = in_valid_i && in_ready_i && (in_mode_i == MODE_CLEAR);
  assign acc_finish = in_valid_i && in_ready_i && (in_mode_i == MODE_FINISH);

  `WPM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `WPM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_matched_i) && $stable(out_overflow_i))
  `WPM_ASSERT_NEXT(a_finish_gives_beat, clk_i, rst_ni, acc_finish, out_valid_i)
  `WPM_ASSERT_NOW(a_beat_from_finish, clk_i, rst_ni, $rose(out_valid_i), $past(acc_finish))
  `WPM_ASSERT_NEXT(a_empty_matches_empty, clk_i, rst_ni, acc_clear ##1 acc_finish, out_valid_i && out_matched_i && !out_overflow_i)

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_mode_i      (in_i.mode),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_matched_i  (out_o.matched),
  .out_overflow_i (out_o.overflow)
);

`default_nettype wire
